[rtl/hltd_pkg.sv]
// ----------------------------------------------------------------------------
// hltd_pkg
// shared types and constants for the head/length/tail deframer
// ----------------------------------------------------------------------------
package hltd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CntW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [ByteW-1:0] HeadReset   = 8'h7F;
  localparam logic [ByteW-1:0] TailReset   = 8'h65;
  localparam logic [LenW-1:0]  MinLenReset = 16'd2;
  localparam logic [LenW-1:0]  MaxLenReset = 16'd1026;
  localparam logic [LenW-1:0]  LenFloor    = 16'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD    = 3'd0,
    REG_TAIL    = 3'd1,
    REG_MIN_LEN = 3'd2,
    REG_MAX_LEN = 3'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TAIL    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_PAYLOAD    = 2'd0,
    EV_ACCEPTED   = 2'd1,
    EV_BAD_TAIL   = 2'd2,
    EV_BAD_LENGTH = 2'd3
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] head;
    logic [ByteW-1:0] tail;
    logic [LenW-1:0]  min_len;
    logic [LenW-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    event_e           code;
    logic [CntW-1:0]  count;
  } res_t;

endpackage

[rtl/head_length_tail_deframer.sv]
// ----------------------------------------------------------------------------
// head_length_tail_deframer
// length-prefixed frame deframer: passes payload words, reports frame status
// a result is registered and shown in the cycle after its input word is accepted
// throughput: one word per cycle while the receiver takes results; the single output register sets the pace
// reset: hunting for the head byte, counter at zero, registers at defaults
// ----------------------------------------------------------------------------
module head_length_tail_deframer import hltd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic [1:0]         event_code_o,
  output logic [CntW-1:0]    frames_accepted_o
);

  cfg_t             cfg_q;
  res_t             core_res;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  event_e           out_code_q;
  logic [CntW-1:0]  out_cnt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head    <= HeadReset;
      cfg_q.tail    <= TailReset;
      cfg_q.min_len <= MinLenReset;
      cfg_q.max_len <= MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAD:    cfg_q.head    <= cfg_wdata_i[ByteW-1:0];
        REG_TAIL:    cfg_q.tail    <= cfg_wdata_i[ByteW-1:0];
        REG_MIN_LEN: cfg_q.min_len <= cfg_wdata_i[LenW-1:0];
        REG_MAX_LEN: cfg_q.max_len <= cfg_wdata_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  hltd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .cfg_i    (cfg_q),
    .res_o    (core_res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (core_res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res.valid) begin
      out_byte_q <= core_res.data;
      out_code_q <= core_res.code;
      out_cnt_q  <= core_res.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign event_code_o      = out_code_q;
  assign frames_accepted_o = out_cnt_q;

  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_code_o != EV_PAYLOAD) |-> out_byte_o == '0)
    else $error("status word carries nonzero data");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  a_result_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res.valid |-> in_valid_i && in_ready_o)
    else $error("result produced without an accepted word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !core_res.valid)
    else $error("pending result overwritten");

endmodule

[rtl/hltd_core.sv]
// ----------------------------------------------------------------------------
// hltd_core
// frame state tracker: one byte per cycle while accept_i is high, gives at most one result per word
// ----------------------------------------------------------------------------
module hltd_core import hltd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   len_full;
  logic [LenW-1:0]   left_dec;
  logic              len_bad;

  assign len_full = {len_hi_q, byte_i};
  assign len_bad  = (len_full < LenFloor) || (len_full < cfg_i.min_len) ||
                    (len_full > cfg_i.max_len);
  assign left_dec = left_q - LenW'(1);

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    res_o.valid = 1'b0;
    res_o.data  = '0;
    res_o.code  = EV_PAYLOAD;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.head) begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_bad) begin
            phase_d     = PH_HUNT;
            left_d      = '0;
            res_o.valid = 1'b1;
            res_o.code  = EV_BAD_LENGTH;
          end else begin
            left_d  = len_full - LenFloor;
            phase_d = (len_full == LenFloor) ? PH_TAIL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_d      = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_TAIL;
          end
          res_o.valid = 1'b1;
          res_o.data  = byte_i;
          res_o.code  = EV_PAYLOAD;
        end
        PH_TAIL: begin
          phase_d     = PH_HUNT;
          res_o.valid = 1'b1;
          if (byte_i == cfg_i.tail) begin
            cnt_d      = cnt_q + CntW'(1);
            res_o.code = EV_ACCEPTED;
          end else begin
            res_o.code = EV_BAD_TAIL;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
    res_o.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_hi_q <= '0;
      left_q   <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the head/length/tail deframer: a scoreboard follows
// the frame state on every accepted input word and checks each result word in
// order, under bursty sending, receiver stalls and several register settings
// ----------------------------------------------------------------------------
module tb_top;
  import hltd_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned FirstFreeReg = 4;
  localparam int unsigned LenTop       = (1 << LenW) - 1;

  typedef struct {
    logic [ByteW-1:0] data;
    event_e           code;
    logic [CntW-1:0]  count;
  } frame_event_t;

  class deframe_scoreboard;
    cfg_t            regs;
    phase_e          phase;
    logic [LenW-1:0] length_value;
    logic [LenW-1:0] bytes_left;
    logic [CntW-1:0] frame_count;
    frame_event_t    events_due[$];
    int unsigned     mismatches;

    function new();
      regs = '{head: HeadReset, tail: TailReset, min_len: MinLenReset, max_len: MaxLenReset};
      phase = PH_HUNT;
      length_value = '0;
      bytes_left = '0;
      frame_count = '0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_HEAD:    regs.head = data[ByteW-1:0];
        REG_TAIL:    regs.tail = data[ByteW-1:0];
        REG_MIN_LEN: regs.min_len = data[LenW-1:0];
        REG_MAX_LEN: regs.max_len = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    function void due_event(logic [ByteW-1:0] data, event_e code);
      frame_event_t ev;
      ev.data = data;
      ev.code = code;
      ev.count = frame_count;
      events_due.push_back(ev);
    endfunction

    function void take_word(logic [ByteW-1:0] b);
      case (phase)
        PH_HUNT: begin
          if (b == regs.head) phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_value = {b, {ByteW{1'b0}}};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_value = {length_value[LenW-1:ByteW], b};
          if (length_value < LenFloor || length_value < regs.min_len ||
              length_value > regs.max_len) begin
            phase = PH_HUNT;
            bytes_left = '0;
            due_event('0, EV_BAD_LENGTH);
          end else begin
            bytes_left = length_value - LenFloor;
            phase = (bytes_left == 0) ? PH_TAIL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) phase = PH_TAIL;
          due_event(b, EV_PAYLOAD);
        end
        PH_TAIL: begin
          phase = PH_HUNT;
          if (b == regs.tail) begin
            frame_count = frame_count + 1'b1;
            due_event('0, EV_ACCEPTED);
          end else begin
            due_event('0, EV_BAD_TAIL);
          end
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void check_event(logic [ByteW-1:0] data, logic [1:0] code,
                              logic [CntW-1:0] count);
      frame_event_t want;
      if (events_due.size() == 0) begin
        report($sformatf("result word with nothing due: byte %h event %0d count %0d",
                         data, code, count));
      end else begin
        want = events_due.pop_front();
        if (data !== want.data)
          report($sformatf("out_byte got %h want %h", data, want.data));
        if (code !== want.code)
          report($sformatf("event_code got %0d want %0d", code, want.code));
        if (count !== want.count)
          report($sformatf("frames_accepted got %0d want %0d", count, want.count));
      end
    endfunction

    function int unsigned pending();
      return events_due.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ByteW-1:0]   in_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ByteW-1:0]   out_byte_o;
  logic [1:0]         event_code_o;
  logic [CntW-1:0]    frames_accepted_o;

  deframe_scoreboard  sb;
  logic [ByteW-1:0]   stream_q[$];
  bit                 hold_req;
  int unsigned        idle_cycles;

  head_length_tail_deframer uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .event_code_o      (event_code_o),
    .frames_accepted_o (frames_accepted_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // result side first, so a word never meets its own expectation in one edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_event(out_byte_o, event_code_o, frames_accepted_o);
      if (in_valid_i && in_ready_o)
        sb.take_word(in_byte_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((k % 5) < 3);
        endcase
      end
    end
  end

  function automatic bit len_ok(input int unsigned len);
    return len <= LenTop && len >= LenFloor &&
           len >= sb.regs.min_len && len <= sb.regs.max_len;
  endfunction

  function automatic void add_frame(input int unsigned len, input bit good_tail);
    logic [LenW-1:0]  lf;
    logic [ByteW-1:0] t;
    int unsigned      k;
    lf = LenW'(len);
    stream_q.push_back(sb.regs.head);
    stream_q.push_back(lf[LenW-1:ByteW]);
    stream_q.push_back(lf[ByteW-1:0]);
    if (len_ok(len)) begin
      for (k = 2; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: stream_q.push_back(sb.regs.head);
          1: stream_q.push_back(sb.regs.tail);
          default: stream_q.push_back(ByteW'($urandom));
        endcase
      end
      t = sb.regs.tail;
      if (!good_tail) t = t ^ ByteW'($urandom_range(1, (1 << ByteW) - 1));
      stream_q.push_back(t);
    end
  endfunction

  // mostly well-formed frames, some bad lengths and bad tails, some line noise
  function automatic void gen_traffic(input int unsigned items);
    int unsigned      target;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      len;
    int unsigned      pick;
    logic [ByteW-1:0] b;
    target = stream_q.size() + items;
    lo = (sb.regs.min_len > LenFloor) ? 32'(sb.regs.min_len) : 32'(LenFloor);
    hi = (sb.regs.max_len < lo + 24) ? 32'(sb.regs.max_len) : lo + 24;
    while (stream_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (lo <= hi && pick < 72) begin
        case ($urandom_range(0, 5))
          0: len = lo;
          1: len = hi;
          default: len = $urandom_range(lo, hi);
        endcase
        add_frame(len, $urandom_range(0, 7) != 0);
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(0, 1);
          1: len = lo - 1;
          2: len = sb.regs.max_len + $urandom_range(1, 16);
          default: len = $urandom_range(0, LenTop);
        endcase
        if (len_ok(len)) len = $urandom_range(0, 1);
        add_frame(len, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          b = ByteW'($urandom);
          if (b == sb.regs.head) b = ~b;
          stream_q.push_back(b);
        end
      end
    end
  endfunction

  task automatic send_word(input logic [ByteW-1:0] b);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic push_stream(input bit bursty);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(1, 40);
    while (stream_q.size() > 0) begin
      send_word(stream_q.pop_front());
      if (bursty && stream_q.size() > 0) begin
        burst_left--;
        if (burst_left == 0) begin
          gap = $urandom_range(0, 8);
          if (gap > 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [ByteW-1:0] head, input logic [ByteW-1:0] tail,
                           input logic [LenW-1:0] min_len, input logic [LenW-1:0] max_len);
    logic [CfgW-1:0] word;
    wait_drained();
    word = CfgW'($urandom);
    word[ByteW-1:0] = head;
    write_reg(REG_HEAD, word);
    word = CfgW'($urandom);
    word[ByteW-1:0] = tail;
    write_reg(REG_TAIL, word);
    write_reg(REG_MIN_LEN, min_len);
    write_reg(REG_MAX_LEN, max_len);
    // unmapped index last, so any aliasing would clobber a live register
    write_reg(CfgIdxW'($urandom_range(FirstFreeReg, (1 << CfgIdxW) - 1)), CfgW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_HEAD;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_byte_i <= '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // noise, empty payload, bad tail, short length, oversize length,
    // bad tail equal to head followed by a clean frame
    stream_q = {8'hFF,
                HeadReset, 8'h00, 8'h02, TailReset,
                HeadReset, 8'h00, 8'h03, 8'hFF, 8'h00,
                HeadReset, 8'h00, 8'h00,
                HeadReset, 8'hFF, 8'hFF,
                HeadReset, 8'h00, 8'h02, HeadReset, 8'h00,
                HeadReset, 8'h00, 8'h03, 8'h55, TailReset};
    push_stream(1'b1);

    configure(8'h00, 8'hFF, LenFloor, LenW'(LenTop));
    add_frame(258, 1'b1);
    gen_traffic(200);
    push_stream(1'b1);

    // min above max: every frame dropped on its length
    configure(8'hFF, 8'h00, LenW'(LenTop), LenFloor);
    gen_traffic(60);
    push_stream(1'b1);

    configure(ByteW'($urandom), ByteW'($urandom),
              LenW'($urandom_range(2, 8)), LenW'($urandom_range(10, 40)));
    gen_traffic(150);
    push_stream(1'b0);
    hold_req = 1'b1;
    gen_traffic(150);
    push_stream(1'b1);
    wait_drained();
    gen_traffic(150);
    push_stream(1'b1);

    configure(8'h55, 8'hAA, 16'd6, 16'd6);
    gen_traffic(100);
    push_stream(1'b1);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
